// ----- sv/gdo_pkg.sv -----
package gdo_pkg;

    localparam int OFFSET_BITS = 17;
    localparam int IDX_W       = OFFSET_BITS + 1;
    localparam int S_FIELDS_W  = 5 + 4 + 14 + OFFSET_BITS;
    localparam int S_DATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_DATA_W    = 24;

    localparam logic [13:0] YEAR_MAX    = 14'd9999;
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SPLIT,
        ST_CHECK,
        ST_STEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic split;
        logic check;
        logic step;
    } ctrl_t;

    typedef struct packed {
        logic bad;
        logic finish;
    } stat_t;

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = 5'd0;
        if (month >= MONTH_JAN && month <= MONTH_DEC) begin
            len = MONTH_LEN[month - MONTH_JAN];
            if (month == 4'd2 && leap) begin
                len = 5'd29;
            end
        end
        return len;
    endfunction

endpackage

// ----- sv/gdo_ctrl.sv -----
module gdo_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    input  logic           out_free,
    input  gdo_pkg::stat_t stat,
    output gdo_pkg::ctrl_t ctrl,
    output logic           in_ready,
    output logic           out_load
);
    import gdo_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:  state_next = ST_SPLIT;
            ST_SPLIT: state_next = ST_CHECK;
            ST_CHECK: begin
                state_next = stat.bad ? ST_DONE : ST_STEP;
            end
            ST_STEP: begin
                if (stat.finish) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl     = '0;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready  = 1'b1;
                ctrl.load = in_valid;
            end
            ST_PREP:  ctrl.prep  = 1'b1;
            ST_SPLIT: ctrl.split = 1'b1;
            ST_CHECK: ctrl.check = 1'b1;
            ST_STEP:  ctrl.step  = 1'b1;
            ST_DONE:  out_load   = out_free;
            default: begin
                ctrl = '0;
            end
        endcase
    end

endmodule

// ----- sv/gdo_step.sv -----
module gdo_step (
    input  logic                           aclk,
    input  gdo_pkg::ctrl_t                 ctrl,
    input  logic [4:0]                     start_day,
    input  logic [3:0]                     start_month,
    input  logic [13:0]                    start_year,
    input  logic [gdo_pkg::OFFSET_BITS-1:0] day_offset,
    output gdo_pkg::stat_t                 stat,
    output logic [4:0]                     result_day,
    output logic [3:0]                     result_month,
    output logic [13:0]                    result_year,
    output logic                           bad_input,
    output logic                           range_error
);
    import gdo_pkg::*;

    logic [4:0]             sd_reg;
    logic [3:0]             sm_reg;
    logic [13:0]            sy_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [3:0]             m_reg;
    logic [13:0]            y_reg;
    logic signed [IDX_W-1:0] idx_reg;
    logic [7:0]             q_reg;
    logic [6:0]             ymod_reg;
    logic [1:0]             cent_reg;
    logic                   bad_reg;
    logic                   rng_reg;

    logic [26:0]            q_prod;
    logic [13:0]            ymod_full;
    logic                   leap;
    logic [4:0]             dim;
    logic [4:0]             dim_prev;
    logic [3:0]             m_prev;
    logic                   fwd;
    logic                   in_month;
    logic                   at_edge;
    logic signed [IDX_W-1:0] step_term;
    logic signed [IDX_W-1:0] idx_init;

    assign q_prod    = 27'(sy_reg) * 27'(RECIP_100);
    assign ymod_full = sy_reg - 14'(q_reg) * 14'd100;

    // century years are leap only when the century count is a multiple of four
    assign leap = (ymod_reg == 7'd0) ? (cent_reg == 2'd0) : (y_reg[1:0] == 2'd0);

    assign m_prev   = (m_reg == MONTH_JAN) ? MONTH_DEC : m_reg - 4'd1;
    assign dim      = days_in(m_reg, leap);
    assign dim_prev = days_in(m_prev, leap);

    assign fwd      = !idx_reg[IDX_W-1];
    assign in_month = fwd && (idx_reg < $signed({{(IDX_W-5){1'b0}}, dim}));
    assign at_edge  = fwd ? (y_reg == YEAR_MAX && m_reg == MONTH_DEC)
                          : (y_reg == 14'd0 && m_reg == MONTH_JAN);

    assign step_term = fwd ? -$signed({{(IDX_W-5){1'b0}}, dim})
                           :  $signed({{(IDX_W-5){1'b0}}, dim_prev});

    assign idx_init = $signed({off_reg[OFFSET_BITS-1], off_reg})
                    + $signed({{(IDX_W-5){1'b0}}, sd_reg}) - $signed(IDX_W'(1));

    assign stat.bad = (sm_reg < MONTH_JAN) || (sm_reg > MONTH_DEC) || (sy_reg > YEAR_MAX)
                   || (sd_reg == 5'd0) || (sd_reg > days_in(sm_reg, leap));
    assign stat.finish = in_month || at_edge;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            sd_reg  <= start_day;
            sm_reg  <= start_month;
            sy_reg  <= start_year;
            off_reg <= day_offset;
            m_reg   <= start_month;
            y_reg   <= start_year;
        end
        if (ctrl.prep) begin
            q_reg   <= q_prod[26:RECIP_SHIFT];
            idx_reg <= idx_init;
        end
        if (ctrl.split) begin
            ymod_reg <= ymod_full[6:0];
            cent_reg <= q_reg[1:0];
        end
        if (ctrl.check) begin
            bad_reg <= stat.bad;
            rng_reg <= 1'b0;
        end
        if (ctrl.step) begin
            if (!in_month && at_edge) begin
                rng_reg <= 1'b1;
            end else if (!in_month) begin
                // move one whole month and carry the day index across
                idx_reg <= idx_reg + step_term;
                if (fwd) begin
                    if (m_reg == MONTH_DEC) begin
                        m_reg    <= MONTH_JAN;
                        y_reg    <= y_reg + 14'd1;
                        ymod_reg <= (ymod_reg == 7'd99) ? 7'd0 : ymod_reg + 7'd1;
                        if (ymod_reg == 7'd99) begin
                            cent_reg <= cent_reg + 2'd1;
                        end
                    end else begin
                        m_reg <= m_reg + 4'd1;
                    end
                end else begin
                    m_reg <= m_prev;
                    if (m_reg == MONTH_JAN) begin
                        y_reg    <= y_reg - 14'd1;
                        ymod_reg <= (ymod_reg == 7'd0) ? 7'd99 : ymod_reg - 7'd1;
                        if (ymod_reg == 7'd0) begin
                            cent_reg <= cent_reg - 2'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (bad_reg || rng_reg) begin
            result_day   = sd_reg;
            result_month = sm_reg;
            result_year  = sy_reg;
        end else begin
            result_day   = idx_reg[4:0] + 5'd1;
            result_month = m_reg;
            result_year  = y_reg;
        end
    end

    assign bad_input   = bad_reg;
    assign range_error = rng_reg;

endmodule

// ----- sv/gregorian_date_offset_unit.sv -----
// Moves a Gregorian date (years 0 to 9999) by a signed day offset and returns the
// new date with two flags: bad_input when the start date is not a real calendar
// date, range_error when the result would leave years 0 to 9999; in both cases the
// start date is returned unchanged. One transaction is worked on at a time: from
// the accepting edge it runs the prep, split and check states, then the month step
// state, which crosses one month boundary per cycle, then the done state, which
// loads the result into the output register; an invalid date skips the month step.
// The largest offset is 65535 days. A held result keeps the unit in the done state.
// The input is accepted again as soon as the result sits in the output register.
module gregorian_date_offset_unit (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // day[4:0], month[8:5], year[22:9], day_offset[OFFSET_BITS+22:23]
    input  logic [gdo_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // day[4:0], month[8:5], year[22:9], zero pad[23]
    output logic [gdo_pkg::M_DATA_W-1:0] m_tdata,
    // bad_input[0], range_error[1]
    output logic [1:0]                   m_tuser
);
    import gdo_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic        out_load;
    logic        out_free;
    logic [4:0]  res_day;
    logic [3:0]  res_month;
    logic [13:0] res_year;
    logic        res_bad;
    logic        res_rng;

    logic                m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;
    logic [1:0]          m_user_reg;

    assign out_free = !m_valid_reg || m_tready;

    gdo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .out_free (out_free),
        .stat     (stat),
        .ctrl     (ctrl),
        .in_ready (s_tready),
        .out_load (out_load)
    );

    gdo_step u_step (
        .aclk         (aclk),
        .ctrl         (ctrl),
        .start_day    (s_tdata[4:0]),
        .start_month  (s_tdata[8:5]),
        .start_year   (s_tdata[22:9]),
        .day_offset   (s_tdata[OFFSET_BITS+22:23]),
        .stat         (stat),
        .result_day   (res_day),
        .result_month (res_month),
        .result_year  (res_year),
        .bad_input    (res_bad),
        .range_error  (res_rng)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {1'b0, res_year, res_month, res_day};
            m_user_reg <= {res_rng, res_bad};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- sv/gdo_checker.sv -----
module gdo_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [gdo_pkg::M_DATA_W-1:0] m_tdata,
    input logic [1:0]                   m_tuser
);
    import gdo_pkg::*;

    // hold a stalled result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // busy after a transaction is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready while working");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("both error flags set");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == 2'b00 |->
            m_tdata[4:0] != 5'd0 && m_tdata[8:5] >= MONTH_JAN && m_tdata[8:5] <= MONTH_DEC
            && m_tdata[22:9] <= YEAR_MAX)
        else $error("result date out of calendar range");

endmodule

bind gregorian_date_offset_unit gdo_checker u_gdo_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
